// ===== rtl/lrpe_pkg.sv =====
// ----------------------------------------------------------------------------
// lrpe_pkg
// Shared types, constants and helpers of the local reference path extractor.
// ----------------------------------------------------------------------------
package lrpe_pkg;

  // Waypoint table and horizon sizing
  localparam int WP_DEPTH    = 1024;
  localparam int WP_AW       = $clog2(WP_DEPTH);
  localparam int CNT_W       = WP_AW + 1;
  localparam int HORIZON_MAX = 32;
  localparam int HZ_W        = 6;
  localparam int IDX_W       = 5;
  localparam int FB_W        = 15;

  // Input item modes
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_ODOM = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZON  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK = 8'd1;

  // Arithmetic constants
  localparam logic signed [14:0] AXLE_OFFSET  = 15'sd11236;
  localparam logic signed [15:0] SPEED_FLOOR  = 16'sd26;
  localparam logic [63:0]        DIST_BOUND   = 64'd4294967296000000000;
  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
  localparam logic signed [33:0] TWO_Q30      = 34'sd2147483648;
  localparam int                 CORDIC_STEPS = 20;
  localparam int                 TRIG_W       = 32;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] speed;
  } wp_t;

  // arctan(2^-i) in 32-bit binary angle units
  function automatic logic signed [33:0] arctan(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:    r = 34'sd536870912;
      5'd1:    r = 34'sd316933406;
      5'd2:    r = 34'sd167458907;
      5'd3:    r = 34'sd85004756;
      5'd4:    r = 34'sd42667331;
      5'd5:    r = 34'sd21354465;
      5'd6:    r = 34'sd10679838;
      5'd7:    r = 34'sd5340245;
      5'd8:    r = 34'sd2670163;
      5'd9:    r = 34'sd1335087;
      5'd10:   r = 34'sd667544;
      5'd11:   r = 34'sd333772;
      5'd12:   r = 34'sd166886;
      5'd13:   r = 34'sd83443;
      5'd14:   r = 34'sd41722;
      5'd15:   r = 34'sd20861;
      5'd16:   r = 34'sd10430;
      5'd17:   r = 34'sd5215;
      5'd18:   r = 34'sd2608;
      5'd19:   r = 34'sd1304;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  // Saturate to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7fffffff;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/lrpe_in_if.sv =====
// ----------------------------------------------------------------------------
// lrpe_in_if
// Input item channel: valid/ready with the item fields.
// ----------------------------------------------------------------------------
interface lrpe_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic               new_path;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;
  logic signed [15:0] speed;

  modport source (output valid, mode, new_path, pos_x, pos_y, heading, speed, input ready);
  modport sink   (input valid, mode, new_path, pos_x, pos_y, heading, speed, output ready);
endinterface

// ===== rtl/lrpe_out_if.sv =====
// ----------------------------------------------------------------------------
// lrpe_out_if
// Result channel: one reference point per beat.
// ----------------------------------------------------------------------------
interface lrpe_out_if
  import lrpe_pkg::*;
;
  logic               valid;
  logic               ready;
  logic signed [31:0] local_x;
  logic signed [31:0] local_y;
  logic signed [15:0] tgt_speed;
  logic [IDX_W-1:0]   point_index;
  logic               last;

  modport source (output valid, local_x, local_y, tgt_speed, point_index, last, input ready);
  modport sink   (input valid, local_x, local_y, tgt_speed, point_index, last, output ready);
endinterface

// ===== rtl/lrpe_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lrpe_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lrpe_cfg_if
  import lrpe_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// ===== rtl/lrpe_cordic.sv =====
// ----------------------------------------------------------------------------
// lrpe_cordic
// Iterative rotation-mode CORDIC: cos and sin of a 16-bit binary angle in
// Q2.30, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module lrpe_cordic
  import lrpe_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [15:0]       angle_i,
  output logic                     done_o,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [4:0]         step_q, step_d;
  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic               flip_q, flip_d;
  logic signed [33:0] z0, tx, ty, xf, yf;

  function automatic logic signed [TRIG_W-1:0] clamp_q30(input logic signed [33:0] v);
    logic signed [TRIG_W-1:0] r;
    if (v > ONE_Q30) r = ONE_Q30[TRIG_W-1:0];
    else if (v < -ONE_Q30) r = TRIG_W'(-ONE_Q30);
    else r = v[TRIG_W-1:0];
    return r;
  endfunction

  // Angle fold into [-pi/2, pi/2] and micro-rotation step
  always_comb begin
    z0     = {{2{angle_i[15]}}, angle_i, 16'd0};
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    flip_d = flip_q;
    tx     = y_q >>> step_q;
    ty     = x_q >>> step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      x_d    = CORDIC_GAIN;
      y_d    = '0;
      flip_d = 1'b0;
      z_d    = z0;
      if (z0 > ONE_Q30) begin
        z_d    = z0 - TWO_Q30;
        flip_d = 1'b1;
      end else if (z0 < -ONE_Q30) begin
        z_d    = z0 + TWO_Q30;
        flip_d = 1'b1;
      end
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_d = x_q - tx;
        y_d = y_q + ty;
        z_d = z_q - arctan(step_q);
      end else begin
        x_d = x_q + tx;
        y_d = y_q - ty;
        z_d = z_q + arctan(step_q);
      end
      step_d = step_q + 5'd1;
      if (step_q == 5'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
  end

  // Result after the last step
  always_comb begin
    xf     = flip_q ? -x_q : x_q;
    yf     = flip_q ? -y_q : y_q;
    cos_o  = clamp_q30(xf);
    sin_o  = clamp_q30(yf);
    done_o = done_q;
  end

endmodule

// ===== rtl/local_reference_path_extractor.sv =====
// Load writes at most one table entry; odometry runs 20 CORDIC steps, the done
// step, the offset multiply and the add; a tick scans the loaded table, then
// emits each horizon point via read, diff, multiply, sum and output states,
// where the output may stall. One item at a time; the scan reads one table
// entry per cycle through the read port of the waypoint memory.
// Reset clears count, pose flag, center, control and scan; the table is kept.
// ----------------------------------------------------------------------------
// local_reference_path_extractor
// Waypoint table in one synchronous memory; nearest-point scan and
// vehicle-frame rotation of the horizon points.
// ----------------------------------------------------------------------------
module local_reference_path_extractor
  import lrpe_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  lrpe_in_if.sink     in_i,
  lrpe_out_if.source  out_o,
  lrpe_cfg_if.sink    cfg_i
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_ODO_ROT = 10'b0000000010,
    S_ODO_MUL = 10'b0000000100,
    S_ODO_ADD = 10'b0000001000,
    S_SCAN    = 10'b0000010000,
    S_EM_RD   = 10'b0000100000,
    S_EM_DIFF = 10'b0001000000,
    S_EM_MUL  = 10'b0010000000,
    S_EM_SUM  = 10'b0100000000,
    S_EM_OUT  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Architectural state
  logic [CNT_W-1:0]         count_q;
  logic signed [31:0]       cx_q, cy_q;
  logic                     pose_q;
  logic [HZ_W-1:0]          horizon_q;
  logic [FB_W-1:0]          fallback_q;
  logic signed [TRIG_W-1:0] cos_q, sin_q;

  // Odometry datapath
  logic signed [31:0]       ox_q, oy_q;
  logic signed [45:0]       offx_q, offy_q;
  logic signed [46:0]       rx_w, ry_w;
  logic                     cordic_start;
  logic                     cordic_done;
  logic signed [TRIG_W-1:0] cordic_cos, cordic_sin;

  // Memory
  wp_t              wp_mem [WP_DEPTH];
  wp_t              rdata_q;
  logic [WP_AW-1:0] raddr;
  logic             we;
  logic [CNT_W-1:0] wr_base;

  // Scan pipeline
  logic [CNT_W-1:0] rd_cnt_q;
  logic             v1_q, v2_q, v3_q;
  logic [WP_AW-1:0] i2_q, i3_q, i1_q;
  logic [31:0]      ax_q, ay_q;
  logic [63:0]      sa_q, sb_q;
  logic [64:0]      dsum_w;
  logic [63:0]      dist_w;
  logic [63:0]      best_q;
  logic [WP_AW-1:0] nearest_q;
  logic             found_q;
  logic signed [32:0] sdx_w, sdy_w;
  logic             scan_issue;

  // Emit datapath
  logic [HZ_W-1:0]    n_q;
  logic [HZ_W-1:0]    pt_q;
  logic [WP_AW-1:0]   idx_q;
  logic signed [32:0] dx_q, dy_q;
  logic signed [15:0] spd_q;
  logic signed [64:0] pxc_q, pys_q, pyc_q, pxs_q;
  logic signed [65:0] lx_w, ly_w;
  logic               last_w;
  logic [CNT_W-1:0]   idx_inc;

  logic in_fire, out_fire, cfg_fire;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = (state_q == S_EM_OUT);

  lrpe_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (in_i.heading),
    .done_o  (cordic_done),
    .cos_o   (cordic_cos),
    .sin_o   (cordic_sin)
  );

  assign cordic_start = in_fire && (in_i.mode == MODE_ODOM);

  // Load write address and enable
  assign wr_base = in_i.new_path ? '0 : count_q;
  assign we      = in_fire && (in_i.mode == MODE_LOAD) && (wr_base < CNT_W'(WP_DEPTH));

  // Read address select
  assign scan_issue = (state_q == S_SCAN) && (rd_cnt_q < count_q);
  assign raddr      = (state_q == S_SCAN) ? rd_cnt_q[WP_AW-1:0] : idx_q;

  // Waypoint memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      wp_mem[wr_base[WP_AW-1:0]] <= '{x: in_i.pos_x, y: in_i.pos_y, speed: in_i.speed};
    end
    rdata_q <= wp_mem[raddr];
  end

  // Distance differences and squared sum
  assign sdx_w  = 33'(rdata_q.x) - 33'(cx_q);
  assign sdy_w  = 33'(rdata_q.y) - 33'(cy_q);
  assign dsum_w = {1'b0, sa_q} + {1'b0, sb_q};
  assign dist_w = dsum_w[64] ? '1 : dsum_w[63:0];

  // Fixed rotations with round half up
  assign rx_w = (47'(offx_q) + 47'sd536870912) >>> 30;
  assign ry_w = (47'(offy_q) + 47'sd536870912) >>> 30;
  assign lx_w = (66'(pxc_q) + 66'(pys_q) + 66'sd536870912) >>> 30;
  assign ly_w = (66'(pyc_q) - 66'(pxs_q) + 66'sd536870912) >>> 30;

  assign last_w  = ((pt_q + HZ_W'(1)) == n_q);
  assign idx_inc = CNT_W'(idx_q) + CNT_W'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.mode == MODE_ODOM) begin
            state_d = S_ODO_ROT;
          end else if (in_i.mode == MODE_TICK && pose_q && count_q != '0) begin
            state_d = S_SCAN;
          end
        end
      end
      S_ODO_ROT: if (cordic_done) state_d = S_ODO_MUL;
      S_ODO_MUL: state_d = S_ODO_ADD;
      S_ODO_ADD: state_d = S_IDLE;
      S_SCAN: begin
        if (rd_cnt_q == count_q && !v1_q && !v2_q && !v3_q) begin
          state_d = (found_q && n_q != '0) ? S_EM_RD : S_IDLE;
        end
      end
      S_EM_RD:   state_d = S_EM_DIFF;
      S_EM_DIFF: state_d = S_EM_MUL;
      S_EM_MUL:  state_d = S_EM_SUM;
      S_EM_SUM:  state_d = S_EM_OUT;
      S_EM_OUT: begin
        if (out_fire) state_d = last_w ? S_IDLE : S_EM_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      pose_q     <= 1'b0;
      cx_q       <= '0;
      cy_q       <= '0;
      horizon_q  <= HZ_W'(10);
      fallback_q <= FB_W'(768);
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      rd_cnt_q   <= '0;
      found_q    <= 1'b0;
      pt_q       <= '0;
    end else begin
      state_q <= state_d;

      // Config writes
      if (cfg_fire) begin
        if (cfg_i.idx == CFG_HORIZON) horizon_q <= cfg_i.data[HZ_W-1:0];
        else if (cfg_i.idx == CFG_FALLBACK) fallback_q <= cfg_i.data[FB_W-1:0];
      end

      // Waypoint count
      if (in_fire && in_i.mode == MODE_LOAD) begin
        count_q <= we ? wr_base + CNT_W'(1) : wr_base;
      end

      // Forward-moved center
      if (state_q == S_ODO_ADD) begin
        cx_q   <= sat32(36'(ox_q) + rx_w[35:0]);
        cy_q   <= sat32(36'(oy_q) + ry_w[35:0]);
        pose_q <= 1'b1;
      end

      // Scan pipeline valids
      v1_q <= scan_issue;
      v2_q <= v1_q && (state_q == S_SCAN);
      v3_q <= v2_q && (state_q == S_SCAN);
      if (state_q == S_IDLE) begin
        rd_cnt_q <= '0;
        found_q  <= 1'b0;
      end else if (scan_issue) begin
        rd_cnt_q <= rd_cnt_q + CNT_W'(1);
      end
      if (v3_q && dist_w < best_q) found_q <= 1'b1;

      // Horizon point counter
      if (state_q == S_SCAN) pt_q <= '0;
      else if (state_q == S_EM_OUT && out_fire) pt_q <= pt_q + HZ_W'(1);
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    // Odometry capture and offset products
    if (cordic_start) begin
      ox_q  <= in_i.pos_x;
      oy_q  <= in_i.pos_y;
    end
    if (state_q == S_ODO_ROT && cordic_done) begin
      cos_q <= cordic_cos;
      sin_q <= cordic_sin;
    end
    offx_q <= AXLE_OFFSET * cos_q;
    offy_q <= AXLE_OFFSET * sin_q;

    // Tick setup
    if (state_q == S_IDLE) begin
      best_q <= DIST_BOUND;
      n_q    <= (horizon_q > HZ_W'(HORIZON_MAX)) ? HZ_W'(HORIZON_MAX) : horizon_q;
    end

    // Scan: absolute differences, squares, compare
    i1_q <= rd_cnt_q[WP_AW-1:0];
    i2_q <= i1_q;
    i3_q <= i2_q;
    ax_q <= sdx_w[32] ? 32'(-sdx_w) : sdx_w[31:0];
    ay_q <= sdy_w[32] ? 32'(-sdy_w) : sdy_w[31:0];
    sa_q <= ax_q * ax_q;
    sb_q <= ay_q * ay_q;
    if (v3_q && dist_w < best_q) begin
      best_q    <= dist_w;
      nearest_q <= i3_q;
    end

    // Emit: walk from the nearest point
    if (state_q == S_SCAN) begin
      idx_q <= nearest_q;
    end else if (state_q == S_EM_OUT && out_fire) begin
      idx_q <= (idx_inc >= count_q) ? '0 : idx_q + WP_AW'(1);
    end
    if (state_q == S_EM_DIFF) begin
      dx_q  <= sdx_w;
      dy_q  <= sdy_w;
      spd_q <= (rdata_q.speed < SPEED_FLOOR) ? 16'({1'b0, fallback_q}) : rdata_q.speed;
    end
    pxc_q <= dx_q * cos_q;
    pys_q <= dy_q * sin_q;
    pyc_q <= dy_q * cos_q;
    pxs_q <= dx_q * sin_q;
    if (state_q == S_EM_SUM) begin
      out_o.local_x     <= sat32(lx_w[35:0]);
      out_o.local_y     <= sat32(ly_w[35:0]);
      out_o.tgt_speed   <= spd_q;
      out_o.point_index <= pt_q[IDX_W-1:0];
      out_o.last        <= last_w;
    end
  end

endmodule

// ===== rtl/lrpe_checker.sv =====
// ----------------------------------------------------------------------------
// lrpe_checker
// Port-level checks of the extractor, bound to the top level.
// ----------------------------------------------------------------------------
module lrpe_checker
  import lrpe_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_local_x,
  input logic               out_last
);

  // A held beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_local_x) && $stable(out_last))
    else $error("output beat changed while stalled");

  // No new item is taken while a point is on offer
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("input ready while output pending");

  // A horizon does not end before its last point
  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last |=> !in_ready)
    else $error("input ready mid horizon");

endmodule

bind local_reference_path_extractor lrpe_checker u_lrpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_local_x (out_o.local_x),
  .out_last    (out_o.last)
);
